FILE: sv/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and word functions of the MT19937 generator core.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;

  localparam int WORD_W = 32;
  localparam int ADDR_W = $clog2(STATE_WORDS);
  // The read index also holds the "due for a twist" and "never seeded" codes.
  localparam int IDX_W  = $clog2(STATE_WORDS + 2);

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] HALF_MASK    = 32'hffff_0000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

  // One generator step is v * 69069 + 1; two steps fold into v * 69069^2 + 69070.
  localparam logic [WORD_W-1:0] LCG_MULT  = 32'd69069;
  localparam logic [WORD_W-1:0] LCG_INC   = 32'd1;
  localparam logic [WORD_W-1:0] LCG_MULT2 = 32'd475559465;
  localparam logic [WORD_W-1:0] LCG_INC2  = 32'd69070;

  // Operation codes carried on tuser.
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_SEED = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  typedef struct packed {
    logic load;  // take a new starting value
    logic step;  // advance by two generator steps
  } lcg_ctrl_t;

  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] mid);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] mag;
    y   = (cur & HIGH_BIT) | (nxt & LOW_BITS);
    mag = y[0] ? TWIST_MATRIX : '0;
    return mid ^ (y >> 1) ^ mag;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: sv/mersenne_twister_generator_core.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator_core
// MT19937 random word generator with its state held in an on-chip RAM.
// ----------------------------------------------------------------------------
// The 624 state words live in one RAM with a single write port and two read
// ports. A draw word on the input stream (tuser = draw) presents one tempered
// 32-bit word on the output when the state is already twisted: the issue
// state starts the registered read of the RAM, and the draw state tempers it
// into the output register, waiting while that register is still occupied.
// The input is ready again after the draw state, so a new draw is only taken
// once the last one is through. Every 624 draws, and on the first draw after
// a seed or a load, the state is twisted in place first: the sweep reads the
// next and the middle word on the two read ports and writes one new word each
// cycle. A seed word refills the whole state from the seed register at one
// word per cycle and gives no result. A load word writes one state word in its
// acceptance cycle and gives no result; a load index of 624 or more is ignored.
// A draw before any seed or in-range load seeds itself with 4357 first. The
// input side takes a new word while a finished result is still waiting on the
// output register. The seed register is written over its own channel, which is
// always ready, and it is meant to be changed only while the block is idle.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration: seed register
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mtg_pkg::WORD_W-1:0] cfg_data,
  // Input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [47:0]                s_tdata,   // [9:0] load_index, [41:10] load_word
  input  logic [1:0]                 s_tuser,   // [1:0] operation
  // Output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mtg_pkg::WORD_W-1:0] m_tdata    // [31:0] random_word
);
  import mtg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_TWIST,
    ST_ISSUE,
    ST_DRAW
  } fsm_t;

  fsm_t fsm;

  // Read index: 0..623 is the next word to draw, STATE_WORDS means a twist is
  // due and STATE_WORDS + 1 means the state has never been seeded.
  logic [IDX_W-1:0]  read_index;
  logic [WORD_W-1:0] seed_reg;
  logic              pend_draw;   // a draw waits behind the current fill

  // Fill and twist sweep counters.
  logic [ADDR_W-1:0] fn;          // word being written by the fill
  logic [IDX_W-1:0]  ri;          // read issue position of the twist
  logic [ADDR_W-1:0] wn;          // word being written by the twist
  logic [ADDR_W-1:0] midp;        // middle word read alongside
  logic              tw_wv;       // the twist write stage holds a word
  logic [WORD_W-1:0] cur;         // the current word, kept from the last read

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr_a;
  logic [ADDR_W-1:0] ram_raddr_b;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;

  lcg_ctrl_t         lcg_ctrl;
  logic [WORD_W-1:0] lcg_seed;
  logic [WORD_W-1:0] fill_word;

  logic              acc;
  logic [1:0]        op;
  logic [ADDR_W-1:0] ld_idx;
  logic [WORD_W-1:0] ld_word;
  logic              ld_ok;
  logic              unseeded;
  logic              tw_done;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (fsm == ST_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign op        = s_tuser;
  assign ld_idx    = s_tdata[ADDR_W-1:0];
  assign ld_word   = s_tdata[41:10];
  // The load index field is exactly ADDR_W bits wide, so no bits are lost.
  assign ld_ok     = (s_tdata[9:0] < 10'(STATE_WORDS));
  assign unseeded  = (read_index == IDX_W'(STATE_WORDS + 1));
  assign tw_done   = tw_wv && (wn == ADDR_W'(STATE_WORDS - 1));
  assign out_free  = !m_tvalid || m_tready;

  // A self-seeding draw starts from the fixed default rather than the register.
  assign lcg_seed      = (op == OP_DRAW) ? DEFAULT_SEED : seed_reg;
  assign lcg_ctrl.load = acc && ((op == OP_SEED) || ((op == OP_DRAW) && unseeded));
  assign lcg_ctrl.step = (fsm == ST_FILL);

  mtg_lcg u_lcg (
    .clk        (clk),
    .ctrl       (lcg_ctrl),
    .seed_value (lcg_seed),
    .fill_word  (fill_word)
  );

  mtg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (rd_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (rd_b)
  );

  // RAM port steering. During the twist port A reads the word at the issue
  // position (word 0 again at the end of the sweep, by then rewritten) and
  // port B the middle word. The write trails the reads and never meets a
  // read of the same word, so no forwarding is needed.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = fn;
    ram_wdata   = fill_word;
    ram_raddr_a = '0;
    ram_raddr_b = midp;
    unique case (fsm)
      ST_IDLE: begin
        if (acc && (op == OP_LOAD) && ld_ok) begin
          ram_we    = 1'b1;
          ram_waddr = ld_idx;
          ram_wdata = ld_word;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_TWIST: begin
        ram_raddr_a = (ri >= IDX_W'(STATE_WORDS)) ? '0 : ri[ADDR_W-1:0];
        ram_we      = tw_wv;
        ram_waddr   = wn;
        ram_wdata   = twist_word(cur, rd_a, rd_b);
      end
      ST_ISSUE, ST_DRAW: begin
        ram_raddr_a = read_index[ADDR_W-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= ST_IDLE;
      read_index <= IDX_W'(STATE_WORDS + 1);
      seed_reg   <= DEFAULT_SEED;
      pend_draw  <= 1'b0;
      tw_wv      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_reg <= cfg_data;
      end
      // In the draw stage the output register is reloaded in the same cycle.
      if (m_tvalid && m_tready && (fsm != ST_DRAW)) begin
        m_tvalid <= 1'b0;
      end

      unique case (fsm)
        ST_IDLE: begin
          if (acc) begin
            case (op)
              OP_DRAW: begin
                if (unseeded) begin
                  fsm       <= ST_FILL;
                  fn        <= '0;
                  pend_draw <= 1'b1;
                end else if (read_index == IDX_W'(STATE_WORDS)) begin
                  fsm   <= ST_TWIST;
                  ri    <= '0;
                  wn    <= '0;
                  midp  <= ADDR_W'(MIDDLE_OFFSET);
                  tw_wv <= 1'b0;
                end else begin
                  fsm <= ST_ISSUE;
                end
              end
              OP_SEED: begin
                fsm       <= ST_FILL;
                fn        <= '0;
                pend_draw <= 1'b0;
              end
              OP_LOAD: begin
                if (ld_ok) begin
                  read_index <= IDX_W'(STATE_WORDS);
                end
              end
              default: begin
                fsm <= ST_IDLE;
              end
            endcase
          end
        end

        ST_FILL: begin
          fn <= fn + 1'b1;
          if (fn == ADDR_W'(STATE_WORDS - 1)) begin
            read_index <= IDX_W'(STATE_WORDS);
            if (pend_draw) begin
              fsm   <= ST_TWIST;
              ri    <= '0;
              wn    <= '0;
              midp  <= ADDR_W'(MIDDLE_OFFSET);
              tw_wv <= 1'b0;
            end else begin
              fsm <= ST_IDLE;
            end
          end
        end

        ST_TWIST: begin
          cur <= rd_a;
          if (ri <= IDX_W'(STATE_WORDS)) begin
            ri <= ri + 1'b1;
            if (ri != '0) begin
              midp <= (midp == ADDR_W'(STATE_WORDS - 1)) ? '0 : midp + 1'b1;
            end
          end
          // Clear again on the last write, where the issue position has run out.
          tw_wv <= (ri != '0) && (ri <= IDX_W'(STATE_WORDS));
          if (tw_wv) begin
            wn <= wn + 1'b1;
          end
          if (tw_done) begin
            read_index <= '0;
            fsm        <= ST_ISSUE;
          end
        end

        ST_ISSUE: begin
          fsm <= ST_DRAW;
        end

        ST_DRAW: begin
          // The read address stays on the drawn word, so the data holds while
          // the output register is still occupied.
          if (out_free) begin
            m_tdata    <= temper(rd_a);
            m_tvalid   <= 1'b1;
            read_index <= read_index + 1'b1;
            fsm        <= ST_IDLE;
          end
        end

        default: begin
          fsm <= ST_IDLE;
        end
      endcase
    end
  end

  // The read index never leaves its meaningful range.
  assert property (@(posedge clk) disable iff (rst)
    read_index <= IDX_W'(STATE_WORDS + 1))
    else $error("read index beyond the unseeded code");

  // A twist write never lands on a word read in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (fsm == ST_TWIST) && ram_we |-> (ram_waddr != ram_raddr_b) && (ram_waddr != ram_raddr_a))
    else $error("twist write collides with a read");

  // A finished twist restarts drawing from the first word.
  assert property (@(posedge clk) disable iff (rst)
    (fsm == ST_TWIST) && tw_done |=> (read_index == '0) && (fsm == ST_ISSUE))
    else $error("twist did not hand over to the first word");

  // A result only appears after the draw stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fsm == ST_DRAW))
    else $error("result word without a draw");

endmodule

FILE: sv/mtg_ram.sv
// ----------------------------------------------------------------------------
// mtg_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/mtg_lcg.sv
// ----------------------------------------------------------------------------
// mtg_lcg
// Linear-congruential seeding unit: one state word per cycle.
// ----------------------------------------------------------------------------
module mtg_lcg (
  input  logic                      clk,
  input  mtg_pkg::lcg_ctrl_t        ctrl,
  input  logic [mtg_pkg::WORD_W-1:0] seed_value,
  output logic [mtg_pkg::WORD_W-1:0] fill_word
);
  import mtg_pkg::*;

  logic [WORD_W-1:0] v;
  logic [WORD_W-1:0] v_one;
  logic [WORD_W-1:0] v_next;

  // Both products come straight from v, so neither waits on the other.
  assign v_one     = v * LCG_MULT + LCG_INC;
  assign v_next    = v * LCG_MULT2 + LCG_INC2;
  assign fill_word = (v & HALF_MASK) | ((v_one & HALF_MASK) >> 16);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= seed_value;
    end else if (ctrl.step) begin
      v <= v_next;
    end
  end

endmodule
